/* design/rgcd_pkg.sv */
`default_nettype none
package rgcd_pkg;

    // Width of one sequence value and of the result.
    localparam int VALUE_WIDTH = 31;
    // Stream data width: the value filled up to whole bytes.
    localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    // The common power of two of two nonzero values is below VALUE_WIDTH.
    localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [SHIFT_WIDTH-1:0] t_shift;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture an accepted request
        logic step;    // one reduction step of the GCD unit
        logic commit;  // write the reduced value into the running result
        logic emit;    // copy the running result to the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;    // one operand has reached zero
        logic last;    // the captured request ends its sequence
    } t_dp_status;

endpackage
`default_nettype wire

/* design/rgcd_ctrl.sv */
`default_nettype none
module rgcd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    input  wire                  i_first,
    input  wire                  i_m_tready,
    input  rgcd_pkg::t_dp_status i_status,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    output rgcd_pkg::t_dp_cmd    o_cmd
);
    import rgcd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_first ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.last || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = w_accept;
            end
            ST_RUN: begin
                o_cmd.step   = !i_status.done;
                o_cmd.commit = i_status.done;
            end
            ST_FINISH: begin
                o_cmd.emit = i_status.last && w_out_free;
            end
            default: begin
                o_cmd      = '0;
                o_s_tready = 1'b0;
            end
        endcase
    end

    // Output valid: set when a result is written, cleared when it is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

/* design/rgcd_dp.sv */
`default_nettype none
module rgcd_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  rgcd_pkg::t_dp_cmd    i_cmd,
    input  rgcd_pkg::t_value     i_value,
    input  wire                  i_first,
    input  wire                  i_last,
    output rgcd_pkg::t_dp_status o_status,
    output rgcd_pkg::t_value     o_result
);
    import rgcd_pkg::*;

    t_value r_running;
    t_value n_running;
    t_value r_a;
    t_value n_a;
    t_value r_b;
    t_value n_b;
    t_shift r_k;
    t_shift n_k;
    logic   r_last;
    t_value r_result;
    t_value w_reduced;
    t_value w_diff_ab;
    t_value w_diff_ba;

    // Once one operand is zero the other, scaled by the common power of two,
    // is the GCD.
    assign w_reduced = (r_a | r_b) << r_k;
    assign w_diff_ab = r_a - r_b;
    assign w_diff_ba = r_b - r_a;

    // Binary GCD step: strip common twos, strip twos of one operand, or
    // replace the larger odd operand by half the difference.
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (i_cmd.load) begin
            n_a = r_running;
            n_b = i_value;
            n_k = '0;
        end else if (i_cmd.step) begin
            if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + t_shift'(1);
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = w_diff_ab >> 1;
            end else begin
                n_b = w_diff_ba >> 1;
            end
        end
    end

    // Running result: a first request loads its value, a reduction replaces it.
    always_comb begin
        n_running = r_running;
        if (i_cmd.load && i_first) begin
            n_running = i_value;
        end else if (i_cmd.commit) begin
            n_running = w_reduced;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
        end else begin
            r_running <= n_running;
        end
    end

    // Operands, flags and output data.
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
        if (i_cmd.load) begin
            r_last <= i_last;
        end
        if (i_cmd.emit) begin
            r_result <= r_running;
        end
    end

    assign o_status.done = (r_a == '0) || (r_b == '0);
    assign o_status.last = r_last;
    assign o_result      = r_result;

endmodule
`default_nettype wire

/* design/running_gcd_sequence.sv */
`default_nettype none
// Running GCD of a stream of unsigned values. A request with tuser (first
// flag) set loads its value as the running result; every other request
// reduces the running result with its value by a binary GCD unit that does
// one shift or one subtract-and-shift per cycle. A request with tlast set
// yields one result, the GCD of the sequence so far, on the master side.
// Zero values in requests without the first flag leave the running result
// unchanged. A first request skips the GCD unit; any other request runs its
// GCD steps one after another on that single shared step unit.
// The next request is accepted while a finished result still waits in the
// output register; a last request waits only if that register is still full.
module running_gcd_sequence (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: value [30:0], zero fill above.
    input  wire  [rgcd_pkg::TDATA_WIDTH-1:0] i_s_tdata,
    input  wire                              i_s_tlast,
    // tuser: first_item [0].
    input  wire                              i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // tdata: gcd_value [30:0], zero fill above.
    output logic [rgcd_pkg::TDATA_WIDTH-1:0] o_m_tdata
);
    import rgcd_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_value     w_result;

    rgcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_first    (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    rgcd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_value  (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_first  (i_s_tuser),
        .i_last   (i_s_tlast),
        .o_status (w_status),
        .o_result (w_result)
    );

    assign o_m_tdata = TDATA_WIDTH'(w_result);

endmodule
`default_nettype wire

/* design/rgcd_checker.sv */
`default_nettype none
module rgcd_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_tvalid,
    input wire                              o_s_tready,
    input wire [rgcd_pkg::TDATA_WIDTH-1:0]  i_s_tdata,
    input wire                              i_s_tlast,
    input wire                              i_s_tuser,
    input wire                              o_m_tvalid,
    input wire                              i_m_tready,
    input wire [rgcd_pkg::TDATA_WIDTH-1:0]  o_m_tdata
);
    import rgcd_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // The unit works on one request at a time.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while busy");

    // A new result appears only after a request finished its work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result without finished request");

    // A request without tlast never produces a result right away.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tlast && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result from a request that is not last");

    // The fill bits above the value stay zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata >> VALUE_WIDTH) == '0)
        else $error("fill bits set in result");

endmodule

bind running_gcd_sequence rgcd_checker u_rgcd_checker (.*);
`default_nettype wire
